### rtl/psem_pkg.sv
// Shared types and constants for the power state energy meter.
package psem_pkg;

  localparam int NUM_STATES = 8;
  localparam int STATE_W    = 3;
  localparam int TIME_W     = 48;
  localparam int POWER_W    = 24;
  localparam int ENERGY_W   = 56;
  localparam int CFG_IDX_W  = 3;

  // elapsed time is split in two halves for the partial products
  localparam int DT_LO_W    = 24;
  localparam int DT_HI_W    = TIME_W - DT_LO_W;
  localparam int PP_LO_W    = POWER_W + DT_LO_W;
  localparam int PP_HI_W    = POWER_W + DT_HI_W;
  // bits of the high partial product that still fit in the energy width
  localparam int PP_HI_KEEP = ENERGY_W - DT_LO_W;

  localparam logic [TIME_W-1:0]   TIME_MAX   = {TIME_W{1'b1}};
  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};
  // 37000 J
  localparam logic [ENERGY_W-1:0] DEFAULT_ENERGY_PJ = 56'd37000000000000000;

  typedef enum logic [1:0] {
    CMD_CHANGE   = 2'd0,
    CMD_READ     = 2'd1,
    CMD_ACTIVATE = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_t;

  typedef enum logic [STATE_W-1:0] {
    ST_OFF       = 3'd0,
    ST_CONNECTED = 3'd1,
    ST_PDSCH_RX  = 3'd2,
    ST_PRACH_TX  = 3'd3,
    ST_PUSCH_TX  = 3'd4,
    ST_EDRX      = 3'd5,
    ST_DRX       = 3'd6,
    ST_IDLE      = 3'd7
  } pstate_t;

  localparam logic [CFG_IDX_W-1:0] CFG_CONNECTED_PWR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWNLINK_PWR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPLINK_PWR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EDRX_PWR      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRX_PWR       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_EDRX      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL       = 3'd6;

endpackage

### rtl/power_state_energy_meter.sv
// Power state energy meter: per-state time and energy accounting with battery drain.
// An input passes the stage 1, 2 and 3 registers, then the result register.
// Throughput: one item per cycle; the pipeline stalls only when the result
// register is full and not taken.
// Stages: decode, two 24x24 partial products, energy saturate, accumulator update.
// Reset zeroes config, control state and totals; remaining energy returns to 37000 J.
module power_state_energy_meter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  logic [1:0]                       command,
  input  logic [psem_pkg::STATE_W-1:0]     new_state,
  input  logic [psem_pkg::TIME_W-1:0]      now_us,
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic [psem_pkg::STATE_W-1:0]     closed_state,
  output logic [psem_pkg::ENERGY_W-1:0]    interval_energy_pj,
  output logic [psem_pkg::TIME_W-1:0]      state_total_time_us,
  output logic [psem_pkg::ENERGY_W-1:0]    state_total_energy_pj,
  output logic [psem_pkg::ENERGY_W-1:0]    remaining_energy_pj,
  output logic                             depleted,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [psem_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psem_pkg::ENERGY_W-1:0]    cfg_data
);
  import psem_pkg::*;

  // configuration
  logic [POWER_W-1:0] connected_power;
  logic [POWER_W-1:0] downlink_power;
  logic [POWER_W-1:0] uplink_power;
  logic [POWER_W-1:0] edrx_power;
  logic [POWER_W-1:0] drx_power;
  logic               use_edrx;

  // metering control state, updated at input transfer
  pstate_t            current_state, current_state_next;
  pstate_t            saved_state, saved_state_next;
  logic               metering_active, metering_active_next;
  logic [TIME_W-1:0]  last_change_us, last_change_us_next;

  // accumulators
  logic [ENERGY_W-1:0] remaining_energy;
  logic [TIME_W-1:0]   time_per_state [NUM_STATES];
  logic [ENERGY_W-1:0] energy_per_state [NUM_STATES];

  // pipeline
  logic               s1_valid;
  pstate_t            s1_closed;
  logic [TIME_W-1:0]  s1_dt;
  logic [POWER_W-1:0] s1_power;

  logic               s2_valid;
  pstate_t            s2_closed;
  logic [TIME_W-1:0]  s2_dt;
  logic [PP_LO_W-1:0] s2_pp_lo;
  logic [PP_HI_W-1:0] s2_pp_hi;

  logic                s3_valid;
  pstate_t             s3_closed;
  logic [TIME_W-1:0]   s3_dt;
  logic [ENERGY_W-1:0] s3_energy;

  logic advance;
  logic accept;

  // stage 1 decode
  cmd_t               cmd;
  pstate_t            ns_mapped;
  pstate_t            closed_sel;
  logic               close_iv;
  logic [TIME_W-1:0]  dt_raw;
  logic [POWER_W-1:0] power_sel;

  // stage 3 combine
  logic                hi_ovf;
  logic [ENERGY_W:0]   energy_sum;
  logic [ENERGY_W-1:0] energy_sat;

  // stage 4 update
  logic [TIME_W:0]     time_sum;
  logic [TIME_W-1:0]   time_new;
  logic [ENERGY_W:0]   etot_sum;
  logic [ENERGY_W-1:0] etot_new;
  logic [ENERGY_W-1:0] remaining_new;

  assign advance    = !result_valid || result_ready;
  assign item_ready = advance;
  assign accept     = item_valid && advance;
  assign cfg_ready  = 1'b1;

  // ---------------------------------------------------------------------------
  // Input decode and control state
  // ---------------------------------------------------------------------------
  always_comb begin
    cmd = cmd_t'(command);
    if (pstate_t'(new_state) == ST_IDLE) begin
      ns_mapped = use_edrx ? ST_EDRX : ST_DRX;
    end else begin
      ns_mapped = pstate_t'(new_state);
    end
    dt_raw = (now_us >= last_change_us) ? (now_us - last_change_us) : '0;

    unique case (current_state)
      ST_OFF:       power_sel = '0;
      ST_CONNECTED: power_sel = connected_power;
      ST_PDSCH_RX:  power_sel = downlink_power;
      ST_PRACH_TX:  power_sel = uplink_power;
      ST_PUSCH_TX:  power_sel = uplink_power;
      ST_EDRX:      power_sel = edrx_power;
      ST_DRX:       power_sel = drx_power;
      ST_IDLE:      power_sel = use_edrx ? edrx_power : drx_power;
      default:      power_sel = '0;
    endcase

    current_state_next   = current_state;
    saved_state_next     = saved_state;
    metering_active_next = metering_active;
    last_change_us_next  = last_change_us;
    closed_sel           = current_state;
    close_iv             = 1'b0;

    unique case (cmd)
      CMD_CHANGE: begin
        if (metering_active) begin
          close_iv            = 1'b1;
          current_state_next  = ns_mapped;
          last_change_us_next = now_us;
        end else begin
          saved_state_next = ns_mapped;
        end
      end
      CMD_READ: begin
        close_iv            = 1'b1;
        last_change_us_next = now_us;
      end
      CMD_ACTIVATE: begin
        metering_active_next = 1'b1;
        last_change_us_next  = now_us;
        current_state_next   = saved_state;
        closed_sel           = saved_state;
      end
      CMD_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      connected_power <= '0;
      downlink_power  <= '0;
      uplink_power    <= '0;
      edrx_power      <= '0;
      drx_power       <= '0;
      use_edrx        <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CONNECTED_PWR: connected_power <= cfg_data[POWER_W-1:0];
        CFG_DOWNLINK_PWR:  downlink_power  <= cfg_data[POWER_W-1:0];
        CFG_UPLINK_PWR:    uplink_power    <= cfg_data[POWER_W-1:0];
        CFG_EDRX_PWR:      edrx_power      <= cfg_data[POWER_W-1:0];
        CFG_DRX_PWR:       drx_power       <= cfg_data[POWER_W-1:0];
        CFG_USE_EDRX:      use_edrx        <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_state   <= ST_OFF;
      saved_state     <= ST_OFF;
      metering_active <= 1'b0;
      last_change_us  <= '0;
      s1_valid        <= 1'b0;
    end else if (advance) begin
      s1_valid <= item_valid;
      if (accept) begin
        current_state   <= current_state_next;
        saved_state     <= saved_state_next;
        metering_active <= metering_active_next;
        last_change_us  <= last_change_us_next;
      end
    end
  end

  // payload of stage 1; no interval closed means zero elapsed time, hence zero charge
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_closed <= closed_sel;
      s1_dt     <= close_iv ? dt_raw : '0;
      s1_power  <= power_sel;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: partial products of power x elapsed time
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_closed <= s1_closed;
      s2_dt     <= s1_dt;
      s2_pp_lo  <= PP_LO_W'(s1_power) * PP_LO_W'(s1_dt[DT_LO_W-1:0]);
      s2_pp_hi  <= PP_HI_W'(s1_power) * PP_HI_W'(s1_dt[TIME_W-1:DT_LO_W]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: combine partial products, saturate at the energy width
  // ---------------------------------------------------------------------------
  always_comb begin
    hi_ovf     = (s2_pp_hi[PP_HI_W-1:PP_HI_KEEP] != '0);
    energy_sum = (ENERGY_W+1)'(s2_pp_lo)
               + (ENERGY_W+1)'({s2_pp_hi[PP_HI_KEEP-1:0], {DT_LO_W{1'b0}}});
    energy_sat = (hi_ovf || energy_sum[ENERGY_W]) ? ENERGY_MAX : energy_sum[ENERGY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_closed <= s2_closed;
      s3_dt     <= s2_dt;
      s3_energy <= energy_sat;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: accumulators and result register
  // ---------------------------------------------------------------------------
  always_comb begin
    time_sum      = (TIME_W+1)'(time_per_state[s3_closed]) + (TIME_W+1)'(s3_dt);
    time_new      = time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];
    etot_sum      = (ENERGY_W+1)'(energy_per_state[s3_closed]) + (ENERGY_W+1)'(s3_energy);
    etot_new      = etot_sum[ENERGY_W] ? ENERGY_MAX : etot_sum[ENERGY_W-1:0];
    remaining_new = (remaining_energy > s3_energy) ? (remaining_energy - s3_energy) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining_energy <= DEFAULT_ENERGY_PJ;
      result_valid     <= 1'b0;
      for (int i = 0; i < NUM_STATES; i++) begin
        time_per_state[i]   <= '0;
        energy_per_state[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_index == CFG_INITIAL) begin
        remaining_energy <= cfg_data;
      end else if (advance && s3_valid) begin
        remaining_energy <= remaining_new;
      end
      if (advance) begin
        result_valid <= s3_valid;
        if (s3_valid) begin
          time_per_state[s3_closed]   <= time_new;
          energy_per_state[s3_closed] <= etot_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s3_valid) begin
      closed_state          <= s3_closed;
      interval_energy_pj    <= s3_energy;
      state_total_time_us   <= time_new;
      state_total_energy_pj <= etot_new;
      remaining_energy_pj   <= remaining_new;
      depleted              <= (remaining_new == '0);
    end
  end

`ifndef ASSERT_OFF
  // battery energy only drops, except when reloaded by configuration
  a_remaining_monotonic: assert property (@(posedge clk) disable iff (rst)
    !(cfg_valid && cfg_index == CFG_INITIAL) |=> remaining_energy <= $past(remaining_energy))
    else $error("remaining energy increased without a reload");

  // generic idle is always resolved before it is stored
  a_idle_mapped: assert property (@(posedge clk) disable iff (rst)
    !(current_state == ST_IDLE || saved_state == ST_IDLE))
    else $error("unmapped idle state held");

  // off draws no power
  a_off_free: assert property (@(posedge clk) disable iff (rst)
    (result_valid && interval_energy_pj != '0) |-> closed_state != ST_OFF)
    else $error("charge reported for off state");

  // per-state total always covers the charge just added
  a_total_covers: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> state_total_energy_pj >= interval_energy_pj)
    else $error("state energy total below interval charge");
`endif

endmodule
